// File: hdl/srfp_pkg.sv
// Shared types and constants for the stepper ramp frame pulser.
package srfp_pkg;

    localparam logic [7:0]  HDR_DIR0       = 8'hFF;
    localparam logic [7:0]  HDR_DIR1       = 8'hFE;
    localparam logic [15:0] INTERVAL_RESET = 16'd10000;
    localparam int          DIV_W          = 16;
    localparam int          DSR_W          = 8;

    typedef enum logic [1:0] {
        REPLY_OK   = 2'd0,
        REPLY_CRC  = 2'd1,
        REPLY_DONE = 2'd2
    } reply_code_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic       reply_valid;
        logic [1:0] reply_code;
        logic       step_clock;
        logic       direction;
        logic       running;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INC_WAIT,
        S_TICK_CHK,
        S_RATE,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic do_byte;
        logic inc_start;
        logic inc_load;
        logic tick_dec;
        logic rate_calc;
        logic reload_int;
        logic div_start;
        logic apply;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_mode;
        logic run;
        logic start_inc;
        logic cd_zero;
        logic rate_zero;
        logic div_done;
        logic slot_free;
    } dp_status_t;

endpackage

// File: hdl/srfp_div.sv
// Restoring divider, one quotient bit per cycle.
module srfp_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [srfp_pkg::DIV_W-1:0] dividend,
    input  logic [srfp_pkg::DSR_W-1:0] divisor,
    output logic                       done,
    output logic [srfp_pkg::DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(srfp_pkg::DIV_W + 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [srfp_pkg::DIV_W-1:0] dvd_reg, dvd_next;
    logic [srfp_pkg::DSR_W-1:0] dsr_reg, dsr_next;
    logic [srfp_pkg::DSR_W-1:0] rem_reg, rem_next;
    logic [srfp_pkg::DSR_W:0]   shifted;
    logic [srfp_pkg::DSR_W:0]   diff;
    logic                       fits;

    assign shifted = {rem_reg, dvd_reg[srfp_pkg::DIV_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(srfp_pkg::DIV_W);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[srfp_pkg::DSR_W-1:0] : shifted[srfp_pkg::DSR_W-1:0];
            dvd_next = {dvd_reg[srfp_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// File: hdl/srfp_dp.sv
// Datapath: frame capture, ramp state, rate and pacing arithmetic, output register.
module srfp_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  srfp_pkg::ctrl_cmd_t  cmd,
    output srfp_pkg::dp_status_t status,
    input  srfp_pkg::in_word_t   in_word,
    input  logic                 cfg_valid,
    input  logic [15:0]          cfg_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output srfp_pkg::out_word_t  out_word
);

    logic                mode_reg;
    logic [7:0]          byte_reg;
    logic [15:0]         interval_reg, interval_next;
    logic [2:0]          pos_reg, pos_next;
    logic [7:0]          a_reg, a_next;
    logic [7:0]          n_reg, n_next;
    logic [7:0]          b_reg, b_next;
    logic [7:0]          inc_reg, inc_next;
    logic [7:0]          rate_reg, rate_next;
    logic                dir_reg, dir_next;
    logic [8:0]          step_reg, step_next;
    logic [7:0]          pulse_reg, pulse_next;
    logic [15:0]         cd_reg, cd_next;
    logic                lvl_reg, lvl_next;
    logic                run_reg, run_next;
    logic                rv_reg, rv_next;
    logic [1:0]          rc_reg, rc_next;
    logic                ov_reg, ov_next;
    srfp_pkg::out_word_t ow_reg;

    logic [8:0]  diff;
    logic        diff_neg;
    logic [8:0]  mag;
    logic        div_start;
    logic [15:0] div_dividend;
    logic [7:0]  div_divisor;
    logic        div_done;
    logic [15:0] div_quot;
    logic [15:0] prod;
    logic [7:0]  pulse_inc;
    logic [8:0]  step_inc;
    logic        slot_free;

    assign diff     = {1'b0, b_reg} - {1'b0, a_reg};
    assign diff_neg = diff[8];
    assign mag      = diff_neg ? (9'd0 - diff) : diff;
    assign prod     = inc_reg * step_reg[7:0];

    assign div_start    = cmd.inc_start | cmd.div_start;
    assign div_dividend = cmd.inc_start ? {8'd0, mag[7:0]} : interval_reg;
    assign div_divisor  = cmd.inc_start ? n_reg : rate_reg;

    srfp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign pulse_inc = pulse_reg + 8'd1;
    assign step_inc  = step_reg + 9'd1;
    assign slot_free = !ov_reg || !out_stall;

    assign status.item_mode = mode_reg;
    assign status.run       = run_reg;
    assign status.start_inc = !mode_reg && !run_reg && (pos_reg == 3'd4)
                              && ((a_reg ^ n_reg ^ b_reg) == byte_reg);
    assign status.cd_zero   = (cd_reg == 16'd0);
    assign status.rate_zero = (rate_reg == 8'd0);
    assign status.div_done  = div_done;
    assign status.slot_free = slot_free;

    always_comb
    begin
        interval_next = cfg_valid ? cfg_word : interval_reg;
        pos_next   = pos_reg;
        a_next     = a_reg;
        n_next     = n_reg;
        b_next     = b_reg;
        inc_next   = inc_reg;
        rate_next  = rate_reg;
        dir_next   = dir_reg;
        step_next  = step_reg;
        pulse_next = pulse_reg;
        cd_next    = cd_reg;
        lvl_next   = lvl_reg;
        run_next   = run_reg;
        rv_next    = rv_reg;
        rc_next    = rc_reg;
        ov_next    = ov_reg && out_stall;

        if (cmd.load_item)
        begin
            rv_next = 1'b0;
            rc_next = srfp_pkg::REPLY_OK;
        end

        if (cmd.do_byte && !run_reg)
        begin
            case (pos_reg)
                3'd0:
                begin
                    if (byte_reg == srfp_pkg::HDR_DIR0 || byte_reg == srfp_pkg::HDR_DIR1)
                    begin
                        dir_next = (byte_reg == srfp_pkg::HDR_DIR1);
                        pos_next = 3'd1;
                    end
                end
                3'd1:
                begin
                    a_next   = byte_reg;
                    pos_next = 3'd2;
                end
                3'd2:
                begin
                    n_next   = byte_reg;
                    pos_next = 3'd3;
                end
                3'd3:
                begin
                    b_next   = byte_reg;
                    pos_next = 3'd4;
                end
                3'd4:
                begin
                    pos_next = 3'd0;
                    rv_next  = 1'b1;
                    if ((a_reg ^ n_reg ^ b_reg) == byte_reg)
                    begin
                        rc_next    = srfp_pkg::REPLY_OK;
                        run_next   = 1'b1;
                        step_next  = 9'd0;
                        pulse_next = 8'd0;
                        cd_next    = 16'd0;
                    end
                    else
                    begin
                        rc_next = srfp_pkg::REPLY_CRC;
                    end
                end
                default:
                begin
                    pos_next = 3'd0;
                end
            endcase
        end

        if (cmd.inc_load)
        begin
            if (n_reg == 8'd0)
                inc_next = 8'd0;
            else
                inc_next = diff_neg ? (8'd0 - div_quot[7:0]) : div_quot[7:0];
        end

        if (cmd.tick_dec && (cd_reg != 16'd0))
            cd_next = cd_reg - 16'd1;

        if (cmd.rate_calc)
            rate_next = a_reg + prod[7:0];

        if (cmd.reload_int)
            cd_next = interval_reg;

        if (cmd.apply)
        begin
            cd_next  = div_quot;
            lvl_next = !lvl_reg;
            if (pulse_inc >= rate_reg)
            begin
                pulse_next = 8'd0;
                step_next  = step_inc;
                if ({1'b0, step_inc} >= ({2'b00, n_reg} + 10'd2))
                begin
                    run_next = 1'b0;
                    pos_next = 3'd0;
                    rv_next  = 1'b1;
                    rc_next  = srfp_pkg::REPLY_DONE;
                end
            end
            else
            begin
                pulse_next = pulse_inc;
            end
        end

        if (cmd.out_load)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= srfp_pkg::INTERVAL_RESET;
            pos_reg      <= 3'd0;
            dir_reg      <= 1'b1;
            step_reg     <= 9'd0;
            pulse_reg    <= 8'd0;
            cd_reg       <= 16'd0;
            lvl_reg      <= 1'b1;
            run_reg      <= 1'b0;
            rv_reg       <= 1'b0;
            rc_reg       <= srfp_pkg::REPLY_OK;
            ov_reg       <= 1'b0;
        end
        else
        begin
            interval_reg <= interval_next;
            pos_reg      <= pos_next;
            dir_reg      <= dir_next;
            step_reg     <= step_next;
            pulse_reg    <= pulse_next;
            cd_reg       <= cd_next;
            lvl_reg      <= lvl_next;
            run_reg      <= run_next;
            rv_reg       <= rv_next;
            rc_reg       <= rc_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= in_word.mode;
            byte_reg <= in_word.rx_byte;
        end
        a_reg    <= a_next;
        n_reg    <= n_next;
        b_reg    <= b_next;
        inc_reg  <= inc_next;
        rate_reg <= rate_next;
        if (cmd.out_load)
        begin
            ow_reg.reply_valid <= rv_reg;
            ow_reg.reply_code  <= rc_reg;
            ow_reg.step_clock  <= lvl_reg;
            ow_reg.direction   <= dir_reg;
            ow_reg.running     <= run_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_word  = ow_reg;

endmodule

// File: hdl/srfp_ctrl.sv
// Controller: sequences one input word at a time through the datapath.
module srfp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  srfp_pkg::dp_status_t status,
    output srfp_pkg::ctrl_cmd_t  cmd
);

    srfp_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srfp_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = srfp_pkg::S_DECODE;
            end
            srfp_pkg::S_DECODE:
            begin
                if (!status.item_mode)
                    state_next = status.start_inc ? srfp_pkg::S_INC_WAIT : srfp_pkg::S_OUT;
                else
                    state_next = status.run ? srfp_pkg::S_TICK_CHK : srfp_pkg::S_OUT;
            end
            srfp_pkg::S_INC_WAIT:
            begin
                if (status.div_done)
                    state_next = srfp_pkg::S_OUT;
            end
            srfp_pkg::S_TICK_CHK:
            begin
                state_next = status.cd_zero ? srfp_pkg::S_RATE : srfp_pkg::S_OUT;
            end
            srfp_pkg::S_RATE:
            begin
                state_next = status.rate_zero ? srfp_pkg::S_OUT : srfp_pkg::S_DIV_WAIT;
            end
            srfp_pkg::S_DIV_WAIT:
            begin
                if (status.div_done)
                    state_next = srfp_pkg::S_OUT;
            end
            srfp_pkg::S_OUT:
            begin
                if (status.slot_free)
                    state_next = srfp_pkg::S_IDLE;
            end
            default:
            begin
                state_next = srfp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            srfp_pkg::S_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_item = in_valid;
            end
            srfp_pkg::S_DECODE:
            begin
                cmd.do_byte   = !status.item_mode;
                cmd.inc_start = !status.item_mode && status.start_inc;
                cmd.tick_dec  = status.item_mode && status.run;
            end
            srfp_pkg::S_INC_WAIT:
            begin
                cmd.inc_load = status.div_done;
            end
            srfp_pkg::S_TICK_CHK:
            begin
                cmd.rate_calc = status.cd_zero;
            end
            srfp_pkg::S_RATE:
            begin
                cmd.reload_int = status.rate_zero;
                cmd.div_start  = !status.rate_zero;
            end
            srfp_pkg::S_DIV_WAIT:
            begin
                cmd.apply = status.div_done;
            end
            srfp_pkg::S_OUT:
            begin
                cmd.out_load = status.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= srfp_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: hdl/stepper_ramp_frame_pulser_core.sv
// Top level of the stepper ramp frame pulser: controller, datapath and assertions.
// Each input word is either a received byte or a one-microsecond tick, and each gives exactly
// one output word with the reply and the step clock, direction and running pin levels. Words
// are taken one at a time: a byte or idle tick passes decode and output, a tick that only
// counts down also the tick check, a tick ending its interval also the rate step and, unless
// the rate is zero, the shared restoring divider forming interval_ticks / rate. The fifth
// byte of a good frame waits while the same divider forms the ramp increment. An output
// word waiting on out_stall delays only the following word's completion. The interval
// register can be written at any time the block is idle; cfg_ready is always high.
module stepper_ramp_frame_pulser_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  srfp_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output srfp_pkg::out_word_t out_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_word
);

    srfp_pkg::ctrl_cmd_t  cmd;
    srfp_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    srfp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    srfp_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_word   (in_word),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_word  (cfg_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while idle state did not advance");

    a_code_zero_without_reply: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.reply_valid || out_word.reply_code == srfp_pkg::REPLY_OK))
        else $error("reply code set without reply");

    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output word appeared without an item in work");

    a_one_load_per_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> !cmd.out_load)
        else $error("output loaded twice for one item");

endmodule

// File: tb/ramp_pulse_checker.sv
`timescale 1ns / 1ps
// Checker for the stepper ramp frame pulser core: predicts every output word and compares.
module ramp_pulse_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  srfp_pkg::in_word_t  in_word,
    input  logic                out_valid,
    input  logic                out_stall,
    input  srfp_pkg::out_word_t out_word,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [15:0]         cfg_word,
    output int                  fail_count
);

    logic [15:0] span_ticks;
    logic [2:0]  frame_pos;
    logic [7:0]  start_rate;
    logic [7:0]  seg_count;
    logic [7:0]  end_rate;
    logic        dir_pin;
    logic [8:0]  step_idx;
    logic [7:0]  pulses_in_step;
    logic [15:0] ticks_left;
    logic        clk_pin;
    logic        ramp_on;

    srfp_pkg::out_word_t awaited[$];
    int                  mismatches = 0;
    int                  outstanding = 0;

    assign fail_count = mismatches + outstanding;

    function automatic logic [7:0] rate_at_step();
        int a;
        int n;
        int b;
        int inc;
        int v;
        a = int'(start_rate);
        n = int'(seg_count);
        b = int'(end_rate);
        inc = (n == 0) ? 0 : (b - a) / n;
        v = a + inc * int'(step_idx);
        return v[7:0];
    endfunction

    task automatic predict_word(input srfp_pkg::in_word_t w, output srfp_pkg::out_word_t o);
        logic [7:0] rate;
        logic       is_tick;
        o = '0;
        is_tick = w.mode;
        if (!is_tick)
        begin
            if (!ramp_on)
            begin
                if (frame_pos == 3'd0)
                begin
                    if (w.rx_byte == srfp_pkg::HDR_DIR0 || w.rx_byte == srfp_pkg::HDR_DIR1)
                    begin
                        dir_pin = (w.rx_byte == srfp_pkg::HDR_DIR1);
                        frame_pos = 3'd1;
                    end
                end
                else
                begin
                    case (frame_pos)
                        3'd1: start_rate = w.rx_byte;
                        3'd2: seg_count = w.rx_byte;
                        3'd3: end_rate = w.rx_byte;
                        default: ;
                    endcase
                    if (frame_pos == 3'd4)
                    begin
                        frame_pos = 3'd0;
                        o.reply_valid = 1'b1;
                        if ((start_rate ^ seg_count ^ end_rate) == w.rx_byte)
                        begin
                            o.reply_code = srfp_pkg::REPLY_OK;
                            ramp_on = 1'b1;
                            step_idx = '0;
                            pulses_in_step = '0;
                            ticks_left = '0;
                        end
                        else
                        begin
                            o.reply_code = srfp_pkg::REPLY_CRC;
                        end
                    end
                    else
                    begin
                        frame_pos = frame_pos + 3'd1;
                    end
                end
            end
        end
        else if (ramp_on)
        begin
            if (ticks_left != 16'd0)
                ticks_left = ticks_left - 16'd1;
            if (ticks_left == 16'd0)
            begin
                rate = rate_at_step();
                if (rate == 8'd0)
                begin
                    ticks_left = span_ticks;
                end
                else
                begin
                    ticks_left = span_ticks / rate;
                    clk_pin = ~clk_pin;
                    pulses_in_step = pulses_in_step + 8'd1;
                    if (pulses_in_step >= rate)
                    begin
                        pulses_in_step = '0;
                        step_idx = step_idx + 9'd1;
                        if (int'(step_idx) >= int'(seg_count) + 2)
                        begin
                            ramp_on = 1'b0;
                            frame_pos = 3'd0;
                            o.reply_valid = 1'b1;
                            o.reply_code = srfp_pkg::REPLY_DONE;
                        end
                    end
                end
            end
        end
        o.step_clock = clk_pin;
        o.direction = dir_pin;
        o.running = ramp_on;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : sample
        srfp_pkg::out_word_t exp_w;
        if (!rst_n)
        begin
            span_ticks = srfp_pkg::INTERVAL_RESET;
            frame_pos = 3'd0;
            start_rate = '0;
            seg_count = '0;
            end_rate = '0;
            dir_pin = 1'b1;
            step_idx = '0;
            pulses_in_step = '0;
            ticks_left = '0;
            clk_pin = 1'b1;
            ramp_on = 1'b0;
            awaited.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                span_ticks = cfg_word;
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: output word with none expected: got %b", $time, out_word);
                    mismatches++;
                end
                else
                begin
                    exp_w = awaited.pop_front();
                    outstanding--;
                    if (out_word.reply_valid !== exp_w.reply_valid
                        || out_word.reply_code !== exp_w.reply_code
                        || out_word.step_clock !== exp_w.step_clock
                        || out_word.direction !== exp_w.direction
                        || out_word.running !== exp_w.running)
                    begin
                        $display({"%0t: output word mismatch: expected valid %0b code %0d ",
                                  "clock %0b dir %0b run %0b, got valid %0b code %0d ",
                                  "clock %0b dir %0b run %0b"}, $time,
                                 exp_w.reply_valid, exp_w.reply_code, exp_w.step_clock,
                                 exp_w.direction, exp_w.running,
                                 out_word.reply_valid, out_word.reply_code,
                                 out_word.step_clock, out_word.direction, out_word.running);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_word(in_word, exp_w);
                awaited.push_back(exp_w);
                outstanding++;
            end
        end
    end

endmodule

// File: tb/tb_stepper_ramp_frame_pulser_core.sv
`timescale 1ns / 1ps
// Testbench top for the stepper ramp frame pulser core: frame and tick stimulus and verdict.
module tb_stepper_ramp_frame_pulser_core;

    localparam logic MODE_BYTE     = 1'b0;
    localparam logic MODE_TICK     = 1'b1;
    localparam int   WORD_TARGET   = 1450;
    localparam int   STALL_LIMIT   = 2000;
    localparam int   SETTLE_CYCLES = 30;
    localparam int   CALM_FROM     = 600;
    localparam int   CALM_TO       = 850;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    srfp_pkg::in_word_t  in_word;
    logic                out_valid;
    logic                out_stall = 1'b0;
    srfp_pkg::out_word_t out_word;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [15:0]         cfg_word;

    int          fail_count;
    int          words_sent;
    int          words_back = 0;
    int          quiet_cycles = 0;
    logic        run_seen = 1'b0;
    logic        calm;
    logic [15:0] span_now;

    stepper_ramp_frame_pulser_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_word  (cfg_word)
    );

    ramp_pulse_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_word   (cfg_word),
        .fail_count (fail_count)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 11);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            words_back <= words_back + 1;
            run_seen <= out_word.running;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic bit take_gap();
        return !calm && ($urandom_range(0, 99) < 11);
    endfunction

    task automatic send_word(input logic mode, input logic [7:0] value);
        if (take_gap())
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while (take_gap());
        end
        in_word <= {mode, value};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] value);
        send_word(MODE_BYTE, value);
    endtask

    task automatic send_tick();
        send_word(MODE_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_replies();
        in_valid <= 1'b0;
        do @(negedge clk); while (words_back != words_sent);
    endtask

    task automatic set_interval(input logic [15:0] value);
        wait_replies();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_word <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        span_now = value;
    endtask

    task automatic send_frame(input logic [7:0] head, a, n, b, check);
        logic [7:0] body [4];
        body = '{a, n, b, check};
        send_byte(head);
        foreach (body[i])
        begin
            if ($urandom_range(0, 5) == 0)
                send_tick();
            send_byte(body[i]);
        end
    endtask

    // ticks a ramp of these parameters takes at the given interval; -1 if it hits a zero rate
    function automatic int ramp_cost(input int a, n, b, span);
        int inc;
        int r;
        int per;
        int total;
        inc = (n == 0) ? 0 : (b - a) / n;
        total = 0;
        for (int s = 0; s <= n + 1; s++)
        begin
            r = (a + inc * s) & 255;
            if (r == 0)
                return -1;
            per = span / r;
            if (per < 1)
                per = 1;
            total += r * per;
        end
        return total;
    endfunction

    task automatic run_ramp(input logic [7:0] head, a, n, b);
        send_frame(head, a, n, b, a ^ n ^ b);
        wait_replies();
        if (run_seen && $urandom_range(0, 2) == 0)
            send_byte($urandom_range(0, 1) ? srfp_pkg::HDR_DIR0 : srfp_pkg::HDR_DIR1);
        for (int k = 0; run_seen && k < 2000; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_byte(8'($urandom_range(0, 253)));
            else
                send_tick();
        end
    endtask

    task automatic random_ramp();
        int  a;
        int  n;
        int  b;
        int  cost;
        int  cap;
        int  tries;
        bit  wide;
        wide = ($urandom_range(0, 9) == 0);
        cap = wide ? 300 : 90;
        tries = 0;
        do
        begin
            a = wide ? $urandom_range(0, 255) : $urandom_range(1, 10);
            b = wide ? $urandom_range(0, 255) : $urandom_range(1, 10);
            n = wide ? $urandom_range(0, 3) : $urandom_range(0, 5);
            cost = ramp_cost(a, n, b, int'(span_now));
            tries++;
        end
        while ((cost < 0 || cost > cap) && tries < 500);
        if (cost < 0 || cost > cap)
        begin
            a = 1;
            n = 0;
            b = 1;
        end
        run_ramp($urandom_range(0, 1) ? srfp_pkg::HDR_DIR1 : srfp_pkg::HDR_DIR0,
                 8'(a), 8'(n), 8'(b));
    endtask

    task automatic bad_frame();
        logic [7:0] a;
        logic [7:0] n;
        logic [7:0] b;
        a = 8'($urandom);
        n = 8'($urandom);
        b = 8'($urandom);
        send_frame($urandom_range(0, 1) ? srfp_pkg::HDR_DIR1 : srfp_pkg::HDR_DIR0, a, n, b,
                   a ^ n ^ b ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(2, 8))
        begin
            if ($urandom_range(0, 1))
                send_tick();
            else
                send_byte(8'($urandom_range(0, 253)));
        end
    endtask

    initial
    begin
        int pick;
        int kind;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_word = '0;
        words_sent = 0;
        calm = 1'b0;
        span_now = srfp_pkg::INTERVAL_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_tick();
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFD);
        send_frame(srfp_pkg::HDR_DIR0, srfp_pkg::HDR_DIR0, 8'h00, srfp_pkg::HDR_DIR1, 8'h55);
        set_interval(16'd0);
        run_ramp(srfp_pkg::HDR_DIR1, 8'd1, 8'd0, 8'd1);

        while (words_sent < WORD_TARGET - 60)
        begin
            calm <= (words_sent >= CALM_FROM && words_sent < CALM_TO);
            pick = $urandom_range(0, 9);
            set_interval(pick == 0 ? 16'd0 : pick == 1 ? 16'd1 : 16'($urandom_range(2, 12)));
            repeat ($urandom_range(3, 6))
            begin
                kind = $urandom_range(0, 19);
                if (kind < 12)
                    random_ramp();
                else if (kind < 17)
                    bad_frame();
                else
                    noise_burst();
            end
        end
        calm <= 1'b0;

        // rate falls 2, 1, 0 and the ramp holds for good
        set_interval(16'd3);
        send_frame(srfp_pkg::HDR_DIR1, 8'd2, 8'd2, 8'd0, 8'd0);
        repeat (20) send_tick();
        set_interval(16'hFFFF);
        repeat (16)
        begin
            case ($urandom_range(0, 3))
                0: send_byte(srfp_pkg::HDR_DIR0);
                1: send_byte(srfp_pkg::HDR_DIR1);
                default: send_tick();
            endcase
        end

        wait_replies();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
hdl/srfp_pkg.sv
hdl/srfp_div.sv
hdl/srfp_dp.sv
hdl/srfp_ctrl.sv
hdl/stepper_ramp_frame_pulser_core.sv
tb/ramp_pulse_checker.sv
tb/tb_stepper_ramp_frame_pulser_core.sv
